### design/cxp_pkg.sv
// Shared constants and types for the circular cross-correlation peak-lag core.
package cxp_pkg;

    localparam int MAX_PHASE   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int LAG_W       = 11;
    localparam int ADDR_W      = $clog2(MAX_PHASE);
    localparam int CNT_W       = $clog2(MAX_PHASE + 1);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + ADDR_W + 1;

    // One closed set handed from the front to the back: its length.
    typedef struct packed {
        logic [CNT_W-1:0] n;
    } t_job;

    // Store write port, driven by the front.
    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] ref_data;
        logic [SAMPLE_BITS-1:0] prof_data;
    } t_wr;

    // Store read port, driven by the back.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] prof_addr;
        logic [ADDR_W-1:0] ref_addr;
    } t_rd;

endpackage

### design/cxp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cxp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/cxp_front.sv
// Front end: accepts sample words, fills the stores and closes each set.
module cxp_front import cxp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [SAMPLE_BITS-1:0] i_ref_sample,
    input  logic [SAMPLE_BITS-1:0] i_prof_sample,
    input  logic                   i_last,
    output logic                   o_full,
    output t_wr                    o_wr,
    output t_job                   o_job,
    output logic                   o_job_push,
    input  logic                   i_job_full,
    input  logic                   i_release
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_hold;
    logic             accept;
    logic             store;
    logic [CNT_W-1:0] count_inc;

    assign o_full    = r_hold || i_job_full;
    assign accept    = i_push && !o_full;
    // Once the store is full further samples are dropped and the count saturates.
    assign store     = accept && (r_count < CNT_W'(MAX_PHASE));
    assign count_inc = store ? r_count + CNT_W'(1) : r_count;

    assign o_wr.en        = store;
    assign o_wr.addr      = r_count[ADDR_W-1:0];
    assign o_wr.ref_data  = i_ref_sample;
    assign o_wr.prof_data = i_prof_sample;

    assign o_job_push = accept && i_last;
    assign o_job.n    = count_inc;

    always_comb begin
        n_count = count_inc;
        if (o_job_push) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hold  <= 1'b0;
        end else begin
            r_count <= n_count;
            // The stores stay locked from the closing word until the back has read them.
            if (o_job_push) begin
                r_hold <= 1'b1;
            end else if (i_release) begin
                r_hold <= 1'b0;
            end
        end
    end

endmodule

### design/cxp_job_queue.sv
// Two-entry queue of closed sets between the front and the back.
module cxp_job_queue import cxp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_data [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### design/cxp_back.sv
// Back end: lag sequencer, multiply-accumulate pipeline, peak search and result queue.
module cxp_back import cxp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_job                   i_job,
    input  logic                   i_job_empty,
    output logic                   o_job_pop,
    output t_rd                    o_rd,
    input  logic [SAMPLE_BITS-1:0] i_prof_data,
    input  logic [SAMPLE_BITS-1:0] i_ref_data,
    output logic                   o_release,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [LAG_W-1:0]       o_lag
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_n_m1, n_n_m1;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [ADDR_W-1:0] r_k, n_k;
    logic              r_release, n_release;

    logic              r_s1_valid, r_s1_first, r_s1_end, r_s1_final;
    logic [ADDR_W-1:0] r_s1_j;
    logic              r_s2_valid, r_s2_first, r_s2_end, r_s2_final;
    logic [ADDR_W-1:0] r_s2_j;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic              r_s3_valid, r_s3_final;
    logic [ADDR_W-1:0] r_s3_j;
    logic signed [ACC_W-1:0]  r_best;
    logic [ADDR_W-1:0] r_best_lag, n_best_lag;

    logic [LAG_W-1:0]  r_q_lag [2];
    logic              r_q_wr, r_q_rd;
    logic [1:0]        r_q_cnt;

    logic              issue, end_i, end_j;
    logic              take, push_res, q_pop;
    logic signed [ACC_W-1:0] prod_ext;
    logic [ADDR_W+LAG_W-1:0] neg_lag;

    assign issue = (r_state == S_ISSUE);
    assign end_i = (r_i == r_n_m1);
    assign end_j = (r_j == r_n_m1);

    assign o_rd.en        = issue;
    assign o_rd.prof_addr = r_i;
    assign o_rd.ref_addr  = r_k;
    assign o_release      = r_release;

    // Sequencer: lag j outer, bin i inner, k = (i + j) mod N kept as a wrapping counter.
    always_comb begin
        n_state   = r_state;
        n_n_m1    = r_n_m1;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_release = 1'b0;
        o_job_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty && (r_q_cnt != 2'd2)) begin
                    o_job_pop = 1'b1;
                    n_n_m1    = ADDR_W'(i_job.n - CNT_W'(1));
                    n_i       = '0;
                    n_j       = '0;
                    n_k       = '0;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (end_i) begin
                    n_i = '0;
                    if (end_j) begin
                        n_state   = S_DRAIN;
                        n_release = 1'b1;
                    end else begin
                        n_j = r_j + ADDR_W'(1);
                        n_k = r_j + ADDR_W'(1);
                    end
                end else begin
                    n_i = r_i + ADDR_W'(1);
                    n_k = (r_k == r_n_m1) ? '0 : r_k + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (push_res) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign prod_ext = {{(ACC_W - PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};
    assign n_acc    = r_s2_first ? prod_ext : r_acc + prod_ext;

    // Peak search: the later lag wins on equal sums.
    assign take       = r_s3_valid && ((r_s3_j == '0) || (r_acc >= r_best));
    assign n_best_lag = take ? r_s3_j : r_best_lag;
    assign push_res   = r_s3_valid && r_s3_final;
    assign neg_lag    = '0 - {{LAG_W{1'b0}}, n_best_lag};

    assign q_pop   = i_pop && (r_q_cnt != 2'd0);
    assign o_empty = (r_q_cnt == 2'd0);
    assign o_lag   = r_q_lag[r_q_rd];

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_i == '0);
        r_s1_end   <= end_i;
        r_s1_final <= end_i && end_j;
        r_s1_j     <= r_j;
        r_s2_first <= r_s1_first;
        r_s2_end   <= r_s1_end;
        r_s2_final <= r_s1_final;
        r_s2_j     <= r_s1_j;
        r_s2_prod  <= $signed(i_prof_data) * $signed(i_ref_data);
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
        r_s3_final <= r_s2_final;
        r_s3_j     <= r_s2_j;
        if (take) begin
            r_best <= r_acc;
        end
        r_best_lag <= n_best_lag;
        if (push_res) begin
            r_q_lag[r_q_wr] <= neg_lag[LAG_W-1:0];
        end
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n_m1     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_release  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_q_wr     <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_cnt    <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_n_m1     <= n_n_m1;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_release  <= n_release;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_end;
            if (push_res) begin
                r_q_wr <= ~r_q_wr;
            end
            if (q_pop) begin
                r_q_rd <= ~r_q_rd;
            end
            r_q_cnt <= r_q_cnt + 2'(push_res) - 2'(q_pop);
        end
    end

endmodule

### design/circular_xcorr_peak_lag_core.sv
// Top level of the circular cross-correlation peak-lag core.
//
// The core takes one word per phase bin, a reference sample and an observed profile sample,
// both signed, into two 1024-entry stores. The word with last set closes the set of N bins;
// the core then forms r[j] = sum over i of prof[i] * ref[(i + j) mod N] for every lag j with
// exact integer arithmetic and delivers one result word holding -j for the largest r[j],
// the highest such lag where several are equal. Words beyond the store depth are dropped,
// so such a set is searched with N = 1024. The search is run by the single
// multiply-accumulate unit, which reads one bin from each store per cycle. While the stores
// are being read the core shows full; full falls once the last pair has been read, so the
// next set can be loaded while the final sums drain. Up to two finished results wait in the
// output queue; a further search does not start while both slots are occupied, and full
// stays high until it does. There is no clearing pass after reset: each search reads only
// bins written for its own set.
module circular_xcorr_peak_lag_core import cxp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] i_ref_sample,
    input  logic [SAMPLE_BITS-1:0] i_prof_sample,
    input  logic                   i_last,
    output logic                   empty,
    input  logic                   pop,
    output logic [LAG_W-1:0]       o_lag
);

    t_wr                    wr;
    t_rd                    rd;
    t_job                   job_in;
    t_job                   job_out;
    logic                   job_push;
    logic                   job_full;
    logic                   job_pop;
    logic                   job_empty;
    logic                   release_stores;
    logic [SAMPLE_BITS-1:0] ref_data;
    logic [SAMPLE_BITS-1:0] prof_data;

    // The front writes the stores and hands each closed set to the job queue.
    cxp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_ref_sample  (i_ref_sample),
        .i_prof_sample (i_prof_sample),
        .i_last        (i_last),
        .o_full        (full),
        .o_wr          (wr),
        .o_job         (job_in),
        .o_job_push    (job_push),
        .i_job_full    (job_full),
        .i_release     (release_stores)
    );

    cxp_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    // Both stores share the write address; the back reads them at independent addresses.
    cxp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PHASE)
    ) u_ref_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.ref_data),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.ref_addr),
        .o_rd_data (ref_data)
    );

    cxp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PHASE)
    ) u_prof_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.prof_data),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.prof_addr),
        .o_rd_data (prof_data)
    );

    // The back runs the search and owns the result queue.
    cxp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_rd        (rd),
        .i_prof_data (prof_data),
        .i_ref_data  (ref_data),
        .o_release   (release_stores),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_lag       (o_lag)
    );

endmodule

### design/cxp_checker.sv
// Port-level checker for the peak-lag core, bound to the top level.
module cxp_checker import cxp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   push,
    input logic                   full,
    input logic [SAMPLE_BITS-1:0] i_ref_sample,
    input logic [SAMPLE_BITS-1:0] i_prof_sample,
    input logic                   i_last,
    input logic                   empty,
    input logic                   pop,
    input logic [LAG_W-1:0]       o_lag
);

    // A waiting result stays put until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_lag)))
        else $error("waiting result changed before it was taken");

    // Nothing waits and nothing blocks straight after reset.
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (empty && !full))
        else $error("core not clear after reset");

    // A delivered lag is never positive and never below -(MAX_PHASE - 1).
    a_lag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_lag == '0) || (o_lag[LAG_W-1] && (o_lag != {1'b1, {(LAG_W-1){1'b0}}}))))
        else $error("lag outside its range");

    // Closing a set locks the stores at once.
    a_close_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_last) |=> full)
        else $error("stores not locked after the closing word");

endmodule

bind circular_xcorr_peak_lag_core cxp_checker u_cxp_checker (.*);

### verif/tb_circular_xcorr_peak_lag_core.sv
// Self-checking testbench for the circular cross-correlation peak-lag core.
`timescale 1ns / 1ps

module tb_circular_xcorr_peak_lag_core import cxp_pkg::*; ();

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [SAMPLE_BITS-1:0] i_ref_sample = '0;
    logic [SAMPLE_BITS-1:0] i_prof_sample = '0;
    logic                   i_last = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [LAG_W-1:0]       o_lag;

    // Percentage of cycles in which each side holds back.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;

    // Our own copy of the set being loaded, and the lags still owed by the core.
    logic signed [SAMPLE_BITS-1:0] ref_bins  [MAX_PHASE];
    logic signed [SAMPLE_BITS-1:0] prof_bins [MAX_PHASE];
    int unsigned                   bins_held = 0;
    logic [LAG_W-1:0]              pending_lags [$];

    circular_xcorr_peak_lag_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_ref_sample  (i_ref_sample),
        .i_prof_sample (i_prof_sample),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_lag         (o_lag)
    );

    always #1 i_clk = ~i_clk;

    // Exact circular correlation over the first n bins; the last lag that reaches the
    // maximum wins, and the result is that lag negated at the output width.
    function automatic logic [LAG_W-1:0] peak_lag_of_set(input int unsigned n);
        longint      best_sum;
        longint      acc;
        int unsigned best_j;
        int unsigned k;
        logic [LAG_W-1:0] lag;
        best_sum = 0;
        best_j = 0;
        for (int unsigned j = 0; j < n; j++) begin
            acc = 0;
            for (int unsigned i = 0; i < n; i++) begin
                k = i + j;
                if (k >= n) begin
                    k = k - n;
                end
                acc += longint'(prof_bins[i]) * longint'(ref_bins[k]);
            end
            if (j == 0 || acc >= best_sum) begin
                best_sum = acc;
                best_j = j;
            end
        end
        lag = LAG_W'(0) - LAG_W'(best_j);
        return lag;
    endfunction

    // Called for every accepted word. Bins beyond the store depth are dropped.
    function automatic void load_bin(input logic [SAMPLE_BITS-1:0] r,
                                     input logic [SAMPLE_BITS-1:0] p,
                                     input logic l);
        if (bins_held < MAX_PHASE) begin
            ref_bins[bins_held] = r;
            prof_bins[bins_held] = p;
            bins_held++;
        end
        if (l) begin
            pending_lags.push_back(peak_lag_of_set(bins_held));
            bins_held = 0;
        end
    endfunction

    // Mostly full-range values, with the extremes mixed in. A narrow sample stays in
    // -1..1 so that equal correlation sums, and hence ties, turn up often.
    function automatic logic [SAMPLE_BITS-1:0] rand_sample(input bit narrow);
        logic [SAMPLE_BITS-1:0] v;
        if (narrow) begin
            v = SAMPLE_BITS'($signed($urandom_range(2)) - 1);
        end else begin
            case ($urandom_range(7))
                0:       v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                1:       v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                2:       v = '0;
                3:       v = '1;
                default: v = SAMPLE_BITS'($urandom);
            endcase
        end
        return v;
    endfunction

    // Entered and left at a falling edge. push is left high on exit, so the next call
    // either keeps it high or lowers it, with one assignment per time step.
    task automatic send_word(input logic [SAMPLE_BITS-1:0] r,
                             input logic [SAMPLE_BITS-1:0] p,
                             input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_ref_sample <= r;
        i_prof_sample <= p;
        i_last <= l;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        load_bin(r, p, l);
        @(negedge i_clk);
    endtask

    // Hold the input off until the core has handed over every result it owes.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_lags.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Receiver: pop is chosen afresh at each falling edge.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each accepted result word is checked against the oldest lag owed.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_lags.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got lag %0d",
                         $time, $signed(o_lag));
                error_count++;
            end else begin
                if (o_lag !== pending_lags[0]) begin
                    $display("%0t: lag mismatch, expected %0d, got %0d",
                             $time, $signed(pending_lags[0]), $signed(o_lag));
                    error_count++;
                end
                void'(pending_lags.pop_front());
            end
        end
    end

    // One-bin sets: the only lag is zero, whatever the samples.
    task automatic test_single_bin();
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh8000, 16'sh8000, 1'b1);
    endtask

    // Both extremes of each field in one set, so the largest products meet.
    task automatic test_extremes();
        send_word(16'sh8000, 16'sh7fff, 1'b0);
        send_word(16'sh7fff, 16'sh8000, 1'b0);
        send_word(16'sh0000, 16'shffff, 1'b0);
        send_word(16'shffff, 16'sh0000, 1'b1);
    endtask

    // Every lag gives the same sum here, so the highest lag must win.
    task automatic test_ties();
        for (int i = 0; i < 5; i++) begin
            send_word(rand_sample(1'b0), '0, i == 4);
        end
        for (int i = 0; i < 3; i++) begin
            send_word(16'sh1234, rand_sample(1'b0), i == 2);
        end
    endtask

    // A short set whose peak sits off lag zero, then a two-bin set.
    task automatic test_shifted_peak();
        send_word(16'sh0000, 16'sh0100, 1'b0);
        send_word(16'sh0000, 16'sh0000, 1'b0);
        send_word(16'sh0100, 16'sh0000, 1'b0);
        send_word(16'sh0000, 16'sh0000, 1'b1);
        send_word(16'sh0001, 16'shfff0, 1'b0);
        send_word(16'sh0002, 16'sh0010, 1'b1);
    endtask

    // The sender stops until the output side is empty, then carries on.
    task automatic test_pause_for_results();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        for (int i = 0; i < 6; i++) begin
            send_word(rand_sample(1'b0), rand_sample(1'b0), i == 5);
        end
        drain_results();
        @(negedge i_clk);
        for (int i = 0; i < 3; i++) begin
            send_word(rand_sample(1'b0), rand_sample(1'b0), i == 2);
        end
    endtask

    // Random sets, mostly short. The last set is always closed.
    task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                               input int unsigned n_words);
        int unsigned sent;
        int unsigned len;
        bit          narrow;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_words) begin
            case ($urandom_range(19))
                0:       len = $urandom_range(80, 41);
                1, 2, 3: len = $urandom_range(40, 13);
                default: len = $urandom_range(12, 1);
            endcase
            narrow = ($urandom_range(9) == 0);
            for (int unsigned k = 0; k < len; k++) begin
                send_word(rand_sample(narrow), rand_sample(narrow), k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_bin();
        test_extremes();
        test_ties();
        test_shifted_peak();
        test_pause_for_results();
        test_random(30, 45, 190);
        test_random(45, 30, 190);
        test_random(0, 0, 190);

        push <= 1'b0;
        while (pending_lags.size() != 0) begin
            @(negedge i_clk);
        end
        // Words that do not close a set cause no result; give the core time to show
        // any stray word before the verdict.
        repeat (200) @(negedge i_clk);

        if (error_count == 0) begin
            $display("PASS circular_xcorr_peak_lag_core");
        end else begin
            $display("FAIL circular_xcorr_peak_lag_core");
        end
        $finish;
    end

    // Sets stay short, so a full run ends long before this timeout, even when every set is
    // as long as the random mix allows.
    initial begin
        #20000000;
        $display("FAIL circular_xcorr_peak_lag_core");
        $finish;
    end

endmodule

### sim.f
design/cxp_pkg.sv
design/cxp_ram.sv
design/cxp_front.sv
design/cxp_job_queue.sv
design/cxp_back.sv
design/circular_xcorr_peak_lag_core.sv
design/cxp_checker.sv
verif/tb_circular_xcorr_peak_lag_core.sv
